// ----- rtl/opr_pkg.sv -----
package opr_pkg;

    // default sizing of the block
    localparam int MAX_REFS_DEF   = 32;
    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 8;

    // fixed widths of the configuration register and the result fields
    localparam int CFG_W      = 5;
    localparam int IDX_W      = 5;
    localparam int PAGE_OUT_W = 8;
    localparam int SLOT_W     = 4;
    localparam int FAULT_W    = 6;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOOKUP,
        ST_SCAN,
        ST_COMMIT
    } opr_state_t;

    // commands from the sequencer to the frame table
    typedef struct packed {
        logic clear_all;
        logic clear_marks;
        logic scan_en;
        logic write_en;
    } frm_cmd_t;

    // status from the frame table to the sequencer
    typedef struct packed {
        logic hit;
        logic empty_found;
        logic all_marked;
    } frm_stat_t;

    // one result item
    typedef struct packed {
        logic [IDX_W-1:0]      ref_index;
        logic [PAGE_OUT_W-1:0] ref_page;
        logic                  hit;
        logic [SLOT_W-1:0]     slot;
        logic                  evicted_valid;
        logic [PAGE_OUT_W-1:0] evicted_page;
        logic [FAULT_W-1:0]    fault_total;
        logic                  last_result;
    } res_t;

endpackage

// ----- rtl/opr_ram.sv -----
module opr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/opr_frames.sv -----
module opr_frames #(
    parameter int MAX_FRAMES = opr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = opr_pkg::PAGE_BITS_DEF,
    parameter int FIDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  opr_pkg::frm_cmd_t          cmd,
    input  logic [PAGE_BITS-1:0]       key,
    input  logic [opr_pkg::CFG_W-1:0]  frames_in_use,
    input  logic [FIDX_W-1:0]          sel_slot,
    input  logic [PAGE_BITS-1:0]       write_page,
    output opr_pkg::frm_stat_t         stat,
    output logic [FIDX_W-1:0]          hit_slot,
    output logic [FIDX_W-1:0]          empty_slot,
    output logic [FIDX_W-1:0]          victim_slot,
    output logic [PAGE_BITS-1:0]       sel_page
);

    import opr_pkg::*;

    logic [PAGE_BITS-1:0]  page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [MAX_FRAMES-1:0] mark_reg, mark_next;
    logic [FIDX_W-1:0]     last_reg, last_next;

    logic [MAX_FRAMES-1:0] active;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [MAX_FRAMES-1:0] unmarked;
    logic [MAX_FRAMES-1:0] newly;
    logic [FIDX_W-1:0]     new_slot;
    logic [FIDX_W-1:0]     unmarked_slot;

    // compare bank: every frame against the key at once
    always_comb
    begin
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            // zero frames acts as one, too many acts as all
            if (frames_in_use == '0)
            begin
                active[j] = (j == 0);
            end
            else
            begin
                active[j] = (j < int'(frames_in_use));
            end
            match[j]    = active[j] && valid_reg[j] && (page_reg[j] == key);
            empty[j]    = active[j] && !valid_reg[j];
            unmarked[j] = active[j] && !mark_reg[j];
            newly[j]    = match[j] && !mark_reg[j];
        end
    end

    // lowest-index encoders
    always_comb
    begin
        hit_slot      = '0;
        empty_slot    = '0;
        new_slot      = '0;
        unmarked_slot = '0;
        for (int j = MAX_FRAMES - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit_slot = FIDX_W'(j);
            end
            if (empty[j])
            begin
                empty_slot = FIDX_W'(j);
            end
            if (newly[j])
            begin
                new_slot = FIDX_W'(j);
            end
            if (unmarked[j])
            begin
                unmarked_slot = FIDX_W'(j);
            end
        end
    end

    always_comb
    begin
        stat.hit         = |match;
        stat.empty_found = |empty;
        stat.all_marked  = ~|unmarked;
        // never used again wins, else the frame found last in the scan
        victim_slot      = stat.all_marked ? last_reg : unmarked_slot;
        sel_page         = page_reg[sel_slot];
    end

    always_comb
    begin
        valid_next = valid_reg;
        mark_next  = mark_reg;
        last_next  = last_reg;
        if (cmd.clear_all)
        begin
            valid_next = '0;
        end
        else if (cmd.write_en)
        begin
            valid_next[sel_slot] = 1'b1;
        end
        if (cmd.clear_marks)
        begin
            mark_next = '0;
        end
        else if (cmd.scan_en && (|newly))
        begin
            mark_next = mark_reg | newly;
            last_next = new_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mark_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        if (cmd.write_en)
        begin
            page_reg[sel_slot] <= write_page;
        end
    end

    // resident pages are distinct; the key is only meaningful once read from a written entry
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(key) |-> $onehot0(match))
        else $error("page resident in more than one frame");

    // a scanned reference can first match at most one frame
    a_mark_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_en |-> $onehot0(newly))
        else $error("several frames marked by one reference");

    // marks only grow during a scan
    a_mark_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.scan_en) && !$past(cmd.clear_marks))
            |-> ((mark_reg & $past(mark_reg)) == $past(mark_reg)))
        else $error("frame mark lost during scan");

endmodule

// ----- rtl/opr_ctrl.sv -----
module opr_ctrl #(
    parameter int MAX_REFS   = opr_pkg::MAX_REFS_DEF,
    parameter int MAX_FRAMES = opr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = opr_pkg::PAGE_BITS_DEF,
    parameter int REF_AW     = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1,
    parameter int FIDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [PAGE_BITS-1:0]  page,
    input  logic                  last_ref,
    input  logic                  out_free,
    output logic                  res_load,
    output opr_pkg::res_t         res,
    output logic                  ram_we,
    output logic [REF_AW-1:0]     ram_waddr,
    output logic [PAGE_BITS-1:0]  ram_wdata,
    output logic [REF_AW-1:0]     ram_raddr,
    input  logic [PAGE_BITS-1:0]  ram_rdata,
    output opr_pkg::frm_cmd_t     frm_cmd,
    input  opr_pkg::frm_stat_t    frm_stat,
    input  logic [FIDX_W-1:0]     hit_slot,
    input  logic [FIDX_W-1:0]     empty_slot,
    input  logic [FIDX_W-1:0]     victim_slot,
    output logic [FIDX_W-1:0]     sel_slot,
    input  logic [PAGE_BITS-1:0]  sel_page,
    output logic [PAGE_BITS-1:0]  write_page
);

    import opr_pkg::*;

    localparam int CNT_W = $clog2(MAX_REFS + 1);

    opr_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 dv_reg, dv_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 hit_reg, hit_next;
    logic                 ev_reg, ev_next;
    logic [FIDX_W-1:0]    slot_reg, slot_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;

    logic                 accept;
    logic                 store_full;
    logic [CNT_W-1:0]     pos_inc;
    logic [FAULT_W-1:0]   fault_inc;

    assign accept     = item_valid && !item_stall;
    assign store_full = (count_reg >= CNT_W'(MAX_REFS));
    assign pos_inc    = pos_reg + CNT_W'(1);
    assign fault_inc  = hit_reg ? fault_reg : fault_reg + FAULT_W'(1);
    assign sel_slot   = slot_reg;
    assign write_page = page_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        scan_next  = scan_reg;
        dv_next    = 1'b0;
        page_next  = page_reg;
        hit_next   = hit_reg;
        ev_next    = ev_reg;
        slot_next  = slot_reg;
        fault_next = fault_reg;

        item_stall = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[REF_AW-1:0];
        ram_wdata  = page;
        ram_raddr  = pos_reg[REF_AW-1:0];
        frm_cmd    = '0;
        res_load   = 1'b0;

        res.ref_index     = IDX_W'(pos_reg);
        res.ref_page      = PAGE_OUT_W'(page_reg);
        res.hit           = hit_reg;
        res.slot          = SLOT_W'(slot_reg);
        res.evicted_valid = ev_reg;
        res.evicted_page  = ev_reg ? PAGE_OUT_W'(sel_page) : '0;
        res.fault_total   = fault_inc;
        res.last_result   = (pos_inc == len_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (accept)
                begin
                    if (!store_full)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_ref)
                    begin
                        len_next          = store_full ? count_reg : count_reg + CNT_W'(1);
                        count_next        = '0;
                        pos_next          = '0;
                        fault_next        = '0;
                        frm_cmd.clear_all = 1'b1;
                        state_next        = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                page_next = ram_rdata;
                hit_next  = frm_stat.hit;
                ev_next   = 1'b0;
                if (frm_stat.hit)
                begin
                    slot_next  = hit_slot;
                    state_next = ST_COMMIT;
                end
                else if (frm_stat.empty_found)
                begin
                    slot_next  = empty_slot;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    ev_next             = 1'b1;
                    frm_cmd.clear_marks = 1'b1;
                    scan_next           = pos_inc;
                    state_next          = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                frm_cmd.scan_en = dv_reg;
                ram_raddr       = scan_reg[REF_AW-1:0];
                if (frm_stat.all_marked || ((scan_reg >= len_reg) && !dv_reg))
                begin
                    slot_next  = victim_slot;
                    state_next = ST_COMMIT;
                end
                else if (scan_reg < len_reg)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    dv_next   = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    res_load         = 1'b1;
                    frm_cmd.write_en = !hit_reg;
                    fault_next       = fault_inc;
                    pos_next         = pos_inc;
                    state_next       = (pos_inc == len_reg) ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            scan_reg  <= '0;
            dv_reg    <= 1'b0;
            fault_reg <= '0;
            hit_reg   <= 1'b0;
            ev_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            scan_reg  <= scan_next;
            dv_reg    <= dv_next;
            fault_reg <= fault_next;
            hit_reg   <= hit_next;
            ev_reg    <= ev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        slot_reg <= slot_next;
    end

    // the final reference starts a replay over a fresh string
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_ref) |=> (state_reg == ST_FETCH && count_reg == '0))
        else $error("replay did not start after final reference");

    // the replay position stays inside the loaded string
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pos_reg < len_reg))
        else $error("replay position beyond string length");

    // the future scan never reads past the string
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg <= len_reg && scan_reg > pos_reg))
        else $error("scan pointer out of range");

    // a result is only issued for a resolved reference
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (state_reg == ST_COMMIT && out_free))
        else $error("result issued outside commit");

endmodule

// ----- rtl/optimal_page_replacement_core.sv -----
// optimal (belady) page replacement engine. a reference string is loaded one
// page per input item, one item per cycle; references beyond MAX_REFS are dropped.
// the item with last_ref high stores its page and starts the replay, during
// which item_stall is high. the replay gives one result item per stored
// reference, in order, with hit or fault, the frame now holding the page, the
// evicted page if any and the running fault count. a hit or a fill of an empty
// frame passes through fetch, lookup and commit; an eviction adds a scan of the
// later references, one per cycle through the single read port of the
// reference memory, each compared against all frames at once, and the scan
// stops early once every frame has been found again. frames and the fault
// count are cleared when a replay starts, marks when a scan starts; the user
// must write frames_in_use only while the block is idle, which the block does
// not enforce; 0 behaves as 1 and values above MAX_FRAMES as MAX_FRAMES
module optimal_page_replacement_core #(
    parameter int MAX_REFS   = opr_pkg::MAX_REFS_DEF,
    parameter int MAX_FRAMES = opr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = opr_pkg::PAGE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_write_en,
    input  logic [opr_pkg::CFG_W-1:0]      cfg_write_data,
    // reference items
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [PAGE_BITS-1:0]           page,
    input  logic                           last_ref,
    // result items
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [opr_pkg::IDX_W-1:0]      ref_index,
    output logic [opr_pkg::PAGE_OUT_W-1:0] ref_page,
    output logic                           hit,
    output logic [opr_pkg::SLOT_W-1:0]     slot,
    output logic                           evicted_valid,
    output logic [opr_pkg::PAGE_OUT_W-1:0] evicted_page,
    output logic [opr_pkg::FAULT_W-1:0]    fault_total,
    output logic                           last_result
);

    import opr_pkg::*;

    localparam int REF_AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    // frames_in_use register
    logic [CFG_W-1:0]     frames_reg;

    // output register, parts the sequencer from the result consumer
    logic                 result_valid_reg, result_valid_next;
    res_t                 res_reg;

    // sequencer to output register
    logic                 out_free;
    logic                 res_load;
    res_t                 res;

    // reference memory
    logic                 ram_we;
    logic [REF_AW-1:0]    ram_waddr;
    logic [PAGE_BITS-1:0] ram_wdata;
    logic [REF_AW-1:0]    ram_raddr;
    logic [PAGE_BITS-1:0] ram_rdata;

    // sequencer to frame table
    frm_cmd_t             frm_cmd;
    frm_stat_t            frm_stat;
    logic [FIDX_W-1:0]    hit_slot;
    logic [FIDX_W-1:0]    empty_slot;
    logic [FIDX_W-1:0]    victim_slot;
    logic [FIDX_W-1:0]    sel_slot;
    logic [PAGE_BITS-1:0] sel_page;
    logic [PAGE_BITS-1:0] write_page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_write_en)
        begin
            frames_reg <= cfg_write_data;
        end
    end

    // room for a new result when empty or when the held one leaves now
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        if (res_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign result_valid  = result_valid_reg;
    assign ref_index     = res_reg.ref_index;
    assign ref_page      = res_reg.ref_page;
    assign hit           = res_reg.hit;
    assign slot          = res_reg.slot;
    assign evicted_valid = res_reg.evicted_valid;
    assign evicted_page  = res_reg.evicted_page;
    assign fault_total   = res_reg.fault_total;
    assign last_result   = res_reg.last_result;

    // reference string store, one write and one registered read per cycle
    opr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_REFS),
        .AW    (REF_AW)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // resident pages with the shared compare bank
    opr_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .FIDX_W     (FIDX_W)
    ) u_frames (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (frm_cmd),
        .key           (ram_rdata),
        .frames_in_use (frames_reg),
        .sel_slot      (sel_slot),
        .write_page    (write_page),
        .stat          (frm_stat),
        .hit_slot      (hit_slot),
        .empty_slot    (empty_slot),
        .victim_slot   (victim_slot),
        .sel_page      (sel_page)
    );

    // load and replay sequencer
    opr_ctrl #(
        .MAX_REFS   (MAX_REFS),
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .REF_AW     (REF_AW),
        .FIDX_W     (FIDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .page        (page),
        .last_ref    (last_ref),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .frm_cmd     (frm_cmd),
        .frm_stat    (frm_stat),
        .hit_slot    (hit_slot),
        .empty_slot  (empty_slot),
        .victim_slot (victim_slot),
        .sel_slot    (sel_slot),
        .sel_page    (sel_page),
        .write_page  (write_page)
    );

endmodule

// ----- verif/tb_optimal_page_replacement_core.sv -----
module tb_optimal_page_replacement_core;

    timeunit 1ns;
    timeprecision 1ps;

    import opr_pkg::*;

    // sizing of the block under test, taken from the package defaults
    localparam int REF_DEPTH   = MAX_REFS_DEF;
    localparam int FRAME_DEPTH = MAX_FRAMES_DEF;
    localparam int PAGE_W      = PAGE_BITS_DEF;

    // stimulus budget and run limits
    localparam int RANDOM_ITEMS = 120;
    localparam int QUIET_AFTER  = 95;      // no idling once this many random items are stored
    localparam int SETTLE_WAIT  = 12;      // cycles for the block to return to idle
    localparam int END_WAIT     = 40;
    localparam int CYCLE_LIMIT  = 300000;

    // ------------------------------------------------------------------
    // scoreboard: keeps its own copy of the reference string and the frame
    // count, replays the string when the final reference arrives and holds
    // the expected result items in arrival order
    // ------------------------------------------------------------------
    class page_scoreboard;
        logic [PAGE_W-1:0] ref_pages[REF_DEPTH];
        int unsigned       ref_total;
        logic [CFG_W-1:0]  frames_setting;
        res_t              expected_q[$];
        int unsigned       mismatches;

        function new();
            ref_total      = 0;
            frames_setting = FRAMES_RESET;
            mismatches     = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        // position of the next use of a page after pos, n when never used again
        function int unsigned next_use_of(logic [PAGE_W-1:0] pg, int unsigned pos,
                                          int unsigned n);
            for (int unsigned k = pos + 1; k < n; k++)
                if (ref_pages[k] == pg)
                    return k;
            return n;
        endfunction

        function void replay_string();
            int unsigned       nf;
            int unsigned       n;
            int unsigned       far;
            int unsigned       u;
            int unsigned       victim;
            logic [PAGE_W-1:0] fr_page[FRAME_DEPTH];
            bit                fr_used[FRAME_DEPTH];
            logic [FAULT_W-1:0] faults;
            logic [PAGE_W-1:0] pg;
            bit                found;
            res_t              r;
            if (frames_setting == 0)
                nf = 1;
            else if (frames_setting > FRAME_DEPTH)
                nf = FRAME_DEPTH;
            else
                nf = frames_setting;
            n      = ref_total;
            faults = '0;
            for (int j = 0; j < FRAME_DEPTH; j++)
            begin
                fr_used[j] = 1'b0;
                fr_page[j] = '0;
            end
            for (int unsigned i = 0; i < n; i++)
            begin
                pg          = ref_pages[i];
                r           = '0;
                r.ref_index = IDX_W'(i);
                r.ref_page  = pg;
                found       = 1'b0;
                for (int unsigned j = 0; j < nf && !found; j++)
                    if (fr_used[j] && fr_page[j] == pg)
                    begin
                        found  = 1'b1;
                        r.hit  = 1'b1;
                        r.slot = SLOT_W'(j);
                    end
                if (!r.hit)
                begin
                    for (int unsigned j = 0; j < nf && !found; j++)
                        if (!fr_used[j])
                        begin
                            found  = 1'b1;
                            r.slot = SLOT_W'(j);
                        end
                    if (!found)
                    begin
                        // lowest frame never used again, else farthest next use
                        far    = 0;
                        victim = 0;
                        for (int unsigned j = 0; j < nf && !found; j++)
                        begin
                            u = next_use_of(fr_page[j], i, n);
                            if (u == n)
                            begin
                                victim = j;
                                found  = 1'b1;
                            end
                            else if (j == 0 || u > far)
                            begin
                                far    = u;
                                victim = j;
                            end
                        end
                        r.slot          = SLOT_W'(victim);
                        r.evicted_valid = 1'b1;
                        r.evicted_page  = fr_page[victim];
                    end
                    fr_page[r.slot] = pg;
                    fr_used[r.slot] = 1'b1;
                    faults++;
                end
                r.fault_total = faults;
                r.last_result = (i + 1 == n);
                expected_q.push_back(r);
            end
        endfunction

        // an accepted reference item
        function void note_ref(logic [PAGE_W-1:0] pg, logic lst);
            if (ref_total < REF_DEPTH)
            begin
                ref_pages[ref_total] = pg;
                ref_total++;
            end
            if (lst)
            begin
                replay_string();
                ref_total = 0;
            end
        endfunction

        task compare_field(string name, int unsigned idx, int unsigned want,
                           int unsigned got);
            if (want != got)
                report_mismatch($sformatf("ref %0d %s expected %0h got %0h",
                                          idx, name, want, got));
        endtask

        // an accepted result item, checked against the oldest expectation
        task check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result for ref %0d", got.ref_index));
                return;
            end
            want = expected_q.pop_front();
            compare_field("ref_index", want.ref_index, want.ref_index, got.ref_index);
            compare_field("ref_page", want.ref_index, want.ref_page, got.ref_page);
            compare_field("hit", want.ref_index, want.hit, got.hit);
            compare_field("slot", want.ref_index, want.slot, got.slot);
            compare_field("evicted_valid", want.ref_index, want.evicted_valid,
                          got.evicted_valid);
            compare_field("evicted_page", want.ref_index, want.evicted_page,
                          got.evicted_page);
            compare_field("fault_total", want.ref_index, want.fault_total, got.fault_total);
            compare_field("last_result", want.ref_index, want.last_result, got.last_result);
        endtask

        task finish_check();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    // ------------------------------------------------------------------
    // block connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_write_en   = 1'b0;
    logic [CFG_W-1:0]       cfg_write_data = '0;
    logic                   item_valid     = 1'b0;
    logic                   item_stall;
    logic [PAGE_W-1:0]      page           = '0;
    logic                   last_ref       = 1'b0;
    logic                   result_valid;
    logic                   result_stall   = 1'b0;
    logic [IDX_W-1:0]       ref_index;
    logic [PAGE_OUT_W-1:0]  ref_page;
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic                   evicted_valid;
    logic [PAGE_OUT_W-1:0]  evicted_page;
    logic [FAULT_W-1:0]     fault_total;
    logic                   last_result;

    res_t                   seen_result;
    page_scoreboard         sb;
    bit                     idling = 1'b1;     // random gaps and stalls allowed
    int unsigned            stored_items;
    int unsigned            cycle_count = 0;

    assign seen_result = {ref_index, ref_page, hit, slot, evicted_valid, evicted_page,
                          fault_total, last_result};

    optimal_page_replacement_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .page           (page),
        .last_ref       (last_ref),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .ref_index      (ref_index),
        .ref_page       (ref_page),
        .hit            (hit),
        .slot           (slot),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .fault_total    (fault_total),
        .last_result    (last_result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // monitors: every signal is driven by nonblocking assignment, so the
    // values read here are those the block saw at this edge
    // ------------------------------------------------------------------
    always @(posedge clk)
        if (rst_n && item_valid && !item_stall)
            sb.note_ref(page, last_ref);

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(seen_result);

    // result side back-pressure in bursts of random length, only while idling is allowed
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver tasks, each entered just after a rising edge
    // ------------------------------------------------------------------

    // one reference item, held until accepted, with an optional gap first
    task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic lst);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_valid <= 1'b1;
        page       <= pg;
        last_ref   <= lst;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // frame count written while the block is idle
    task automatic write_frames(input logic [CFG_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.frames_setting = value;
    endtask

    // all expected results back, then let the block settle into idle;
    // the first wait on an edge lets the final reference reach the scoreboard
    task automatic wait_drained();
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // a fixed string, final item marked
    task automatic send_string(input logic [PAGE_W-1:0] pages[$]);
        foreach (pages[k])
            send_ref(pages[k], k == pages.size() - 1);
        item_valid <= 1'b0;
        wait_drained();
    endtask

    // a random string over a window of pages; pool of 256 spans all pages
    task automatic random_string(input int unsigned len, input int unsigned pool);
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] pg;
        base = PAGE_W'($urandom_range(0, 255));
        for (int unsigned k = 0; k < len; k++)
        begin
            if (pool >= 256)
                pg = PAGE_W'($urandom_range(0, 255));
            else
                pg = base + PAGE_W'($urandom_range(0, pool - 1));
            send_ref(pg, k == len - 1);
            // references past the store depth are dropped by the block
            if (k < REF_DEPTH)
                stored_items++;
        end
        item_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic random_strings();
        int unsigned      strings_done;
        int unsigned      len;
        int unsigned      pool;
        logic [CFG_W-1:0] setting;
        strings_done = 0;
        stored_items = 0;
        while (stored_items < RANDOM_ITEMS)
        begin
            // the tail of the run goes at full rate
            if (stored_items >= QUIET_AFTER)
                idling = 1'b0;
            case (strings_done)
                0:       setting = CFG_W'(FRAME_DEPTH);
                1:       setting = CFG_W'(31);
                2:       setting = CFG_W'(FRAME_DEPTH + 1);
                default: setting = ($urandom_range(0, 3) == 0) ?
                                   CFG_W'($urandom_range(0, 31)) :
                                   CFG_W'($urandom_range(1, 6));
            endcase
            write_frames(setting);
            // now and then overfill the store
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(REF_DEPTH + 1, REF_DEPTH + 4);
            else
                len = $urandom_range(1, 24);
            pool = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(2, 10);
            random_string(len, pool);
            strings_done++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame count: extreme pages, fills then hits
        send_string('{8'h00, 8'hff, 8'h00, 8'hff});
        // one frame: every miss after the first evicts
        write_frames(CFG_W'(1));
        send_string('{8'haa, 8'h55, 8'haa});
        // zero frames behaves as one; a lone reference, then a repeat
        write_frames(CFG_W'(0));
        send_string('{8'h07});
        send_string('{8'h07, 8'h07});
        // three frames on the classic string: never-used-again and farthest victims
        write_frames(CFG_W'(3));
        send_string('{8'd1, 8'd2, 8'd3, 8'd4, 8'd1, 8'd2, 8'd5, 8'd1, 8'd2, 8'd3,
                      8'd4, 8'd5});

        random_strings();

        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        sb.finish_check();
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
